[design/multi_queue_shared_buffer_top_assert.svh]
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top_assert.svh
// assertion macros used by mqsb_core of the multi queue shared buffer
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_TOP_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_TOP_ASSERT_SVH

// expression holds at every edge out of reset
`define MQSB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("mqsb invariant violated");

// consequent holds in the same cycle as the antecedent
`define MQSB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mqsb implication violated");

// consequent holds in the cycle after the antecedent
`define MQSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mqsb next-cycle check violated");

`endif

[design/mqsb_pkg.sv]
// ----------------------------------------------------------------------------
// mqsb_pkg
// types and constants of the multi queue shared buffer
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

	localparam int DATA_W         = 32;
	localparam int KIND_W         = 2;
	localparam int QNUM_W         = 2;
	localparam int STATUS_W       = 2;
	localparam int NUM_QUEUES_DEF = 4;
	localparam int SLOTS_DEF      = 64;

	localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	// which prefetched link read is in flight
	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_FREE,
		PEND_QUEUE
	} pend_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [QNUM_W-1:0]        queue_number;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic                     queue_empty;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
	} result_t;

endpackage

`default_nettype wire

[design/mqsb_link_ram.sv]
// ----------------------------------------------------------------------------
// mqsb_link_ram
// slot link store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_link_ram #(
	parameter int SLOTS = mqsb_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [$clog2(SLOTS)-1:0]     waddr,
	input  wire logic [$clog2(SLOTS+1)-1:0]   wdata,
	input  wire logic                         re,
	input  wire logic [$clog2(SLOTS)-1:0]     raddr,
	output logic      [$clog2(SLOTS+1)-1:0]   rdata
);

	localparam int PW = $clog2(SLOTS+1);

	logic [PW-1:0]    mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [PW-1:0]    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// an unwritten slot reads as a link to the next slot
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem[raddr] : PW'(raddr) + PW'(1);
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/mqsb_data_ram.sv]
// ----------------------------------------------------------------------------
// mqsb_data_ram
// successor data store: the entry of a slot holds the word of the slot it
// links to; one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_data_ram #(
	parameter int SLOTS = mqsb_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(SLOTS)-1:0]      waddr,
	input  wire logic [mqsb_pkg::DATA_W-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [$clog2(SLOTS)-1:0]      raddr,
	output logic      [mqsb_pkg::DATA_W-1:0]   rdata
);

	logic [mqsb_pkg::DATA_W-1:0] mem [SLOTS];
	logic [mqsb_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/mqsb_core.sv]
// ----------------------------------------------------------------------------
// mqsb_core
// queue pointer state, free list and slot stores; one operation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_queue_shared_buffer_top_assert.svh"

module mqsb_core #(
	parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
	parameter int SLOTS      = mqsb_pkg::SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              exec,
	input  wire mqsb_pkg::item_t   item,
	output mqsb_pkg::result_t      result
);

	localparam int AW  = $clog2(SLOTS);
	localparam int PW  = $clog2(SLOTS+1);
	localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int DW  = mqsb_pkg::DATA_W;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	// control state
	logic [PW-1:0]         free_head_q, free_head_d;
	logic [PW-1:0]         fnext_q, fnext_d, fnext_e;
	logic [PW-1:0]         head_q [NUM_QUEUES];
	logic [PW-1:0]         head_d [NUM_QUEUES];
	mqsb_pkg::pend_t       pend_q, pend_d;
	logic [QIW-1:0]        pend_qi_q, pend_qi_d;

	// payload state: tail slot, link of head slot and the cached data words
	logic [AW-1:0]         tail_q  [NUM_QUEUES];
	logic [AW-1:0]         tail_d  [NUM_QUEUES];
	logic [AW-1:0]         hnext_q [NUM_QUEUES];
	logic [AW-1:0]         hnext_d [NUM_QUEUES];
	logic [AW-1:0]         hnext_e [NUM_QUEUES];
	logic [DW-1:0]         hdata_q [NUM_QUEUES];
	logic [DW-1:0]         hdata_d [NUM_QUEUES];
	logic [DW-1:0]         hdata_e [NUM_QUEUES];
	logic [DW-1:0]         front_q [NUM_QUEUES];
	logic [DW-1:0]         front_d [NUM_QUEUES];
	logic [DW-1:0]         back_q  [NUM_QUEUES];
	logic [DW-1:0]         back_d  [NUM_QUEUES];

	// store ports
	logic                  link_we, link_re, data_we, data_re;
	logic [AW-1:0]         link_waddr, link_raddr, data_waddr, data_raddr;
	logic [PW-1:0]         link_rdata;
	logic [DW-1:0]         data_rdata;

	logic                  q_ok, is_empty, is_one, three_plus;
	logic                  push_ok, pop_ok, empty_after;
	logic [QIW-1:0]        qi;
	logic [PW-1:0]         h;
	logic [AW-1:0]         t;
	logic [mqsb_pkg::STATUS_W-1:0] status;

	mqsb_link_ram #(.SLOTS(SLOTS)) u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (link_we),
		.waddr  (link_waddr),
		.wdata  (free_head_q),
		.re     (link_re),
		.raddr  (link_raddr),
		.rdata  (link_rdata)
	);

	mqsb_data_ram #(.SLOTS(SLOTS)) u_data (
		.clk    (clk),
		.we     (data_we),
		.waddr  (data_waddr),
		.wdata  (item.value),
		.re     (data_re),
		.raddr  (data_raddr),
		.rdata  (data_rdata)
	);

	// fold in the link read issued in the previous cycle
	always_comb begin
		fnext_e = (pend_q == mqsb_pkg::PEND_FREE) ? link_rdata : fnext_q;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (pend_q == mqsb_pkg::PEND_QUEUE && pend_qi_q == QIW'(i)) begin
				hnext_e[i] = link_rdata[AW-1:0];
				hdata_e[i] = data_rdata;
			end else begin
				hnext_e[i] = hnext_q[i];
				hdata_e[i] = hdata_q[i];
			end
		end
	end

	always_comb begin
		q_ok       = 32'(item.queue_number) < 32'(NUM_QUEUES);
		qi         = QIW'(item.queue_number);
		h          = head_q[qi];
		t          = tail_q[qi];
		is_empty   = (h == NIL);
		is_one     = !is_empty && (h[AW-1:0] == t);
		three_plus = !is_empty && !is_one && (hnext_e[qi] != t);
		push_ok    = exec && q_ok && item.kind == mqsb_pkg::KIND_PUSH && free_head_q != NIL;
		pop_ok     = exec && q_ok && item.kind == mqsb_pkg::KIND_POP && !is_empty;
	end

	always_comb begin
		free_head_d = free_head_q;
		fnext_d     = fnext_e;
		pend_d      = mqsb_pkg::PEND_NONE;
		pend_qi_d   = pend_qi_q;
		head_d      = head_q;
		tail_d      = tail_q;
		hnext_d     = hnext_e;
		hdata_d     = hdata_e;
		front_d     = front_q;
		back_d      = back_q;
		link_we     = 1'b0;
		link_waddr  = t;
		link_re     = 1'b0;
		link_raddr  = fnext_e[AW-1:0];
		data_we     = 1'b0;
		data_waddr  = t;
		data_re     = 1'b0;
		data_raddr  = hnext_e[qi];
		status      = mqsb_pkg::STAT_DONE;

		if (exec && q_ok) begin
			case (item.kind)
				mqsb_pkg::KIND_PUSH: begin
					if (free_head_q == NIL) begin
						status = mqsb_pkg::STAT_FULL;
					end else begin
						free_head_d = fnext_e;
						if (fnext_e != NIL) begin
							link_re = 1'b1;
							pend_d  = mqsb_pkg::PEND_FREE;
						end
						if (is_empty) begin
							head_d[qi]  = free_head_q;
							front_d[qi] = item.value;
						end else begin
							// old tail now links to the new slot and carries its word
							link_we = 1'b1;
							data_we = 1'b1;
							if (is_one) begin
								hnext_d[qi] = free_head_q[AW-1:0];
								hdata_d[qi] = item.value;
							end
						end
						tail_d[qi] = free_head_q[AW-1:0];
						back_d[qi] = item.value;
					end
				end
				mqsb_pkg::KIND_POP: begin
					if (is_empty) begin
						status = mqsb_pkg::STAT_EMPTY;
					end else begin
						// head slot goes back on top of the free list
						link_we     = 1'b1;
						link_waddr  = h[AW-1:0];
						free_head_d = h;
						fnext_d     = free_head_q;
						if (is_one) begin
							head_d[qi] = NIL;
						end else begin
							head_d[qi]  = PW'(hnext_e[qi]);
							front_d[qi] = hdata_e[qi];
							if (three_plus) begin
								link_re    = 1'b1;
								link_raddr = hnext_e[qi];
								data_re    = 1'b1;
								pend_d     = mqsb_pkg::PEND_QUEUE;
								pend_qi_d  = qi;
							end
						end
					end
				end
				default: begin
					status = mqsb_pkg::STAT_DONE;
				end
			endcase
		end
	end

	always_comb begin
		empty_after = !q_ok || head_d[qi] == NIL;
		result.status      = status;
		result.queue_empty = empty_after;
		result.front_value = empty_after ? '0 : front_d[qi];
		result.back_value  = empty_after ? '0 : back_d[qi];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fnext_q     <= PW'(1);
			pend_q      <= mqsb_pkg::PEND_NONE;
			pend_qi_q   <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= NIL;
			end
		end else begin
			free_head_q <= free_head_d;
			fnext_q     <= fnext_d;
			pend_q      <= pend_d;
			pend_qi_q   <= pend_qi_d;
			head_q      <= head_d;
		end
	end

	always_ff @(posedge clk) begin
		tail_q  <= tail_d;
		hnext_q <= hnext_d;
		hdata_q <= hdata_d;
		front_q <= front_d;
		back_q  <= back_d;
	end

	`MQSB_ASSERT_IMPLIES(a_pend_free_has_head, clk, arst_n, pend_q == mqsb_pkg::PEND_FREE, free_head_q != NIL)
	`MQSB_ASSERT_IMPLIES(a_pend_queue_two_plus, clk, arst_n, pend_q == mqsb_pkg::PEND_QUEUE, head_q[pend_qi_q] != NIL && head_q[pend_qi_q][AW-1:0] != tail_q[pend_qi_q])
	`MQSB_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, push_ok, head_q[$past(qi)] != NIL)
	`MQSB_ASSERT_NEXT(a_pop_frees_head, clk, arst_n, pop_ok, free_head_q == $past(h))

endmodule

`default_nettype wire

[design/multi_queue_shared_buffer_top.sv]
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// several fifo queues in one shared slot store with a linked free list
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one operation per transaction: tuser holds kind and queue
//   number, tdata the value to push. m_axis returns exactly one result per
//   operation: tuser holds status and queue_empty, tdata front and back value.
//   an operation passes the input register and then the result register before
//   its result shows on m_axis. throughput is one operation per cycle while
//   m_axis takes results; the link store prefetches the next link of the free
//   head and of each queue head, so consecutive operations on the same queue
//   never wait.
//   reset empties every queue and threads all slots into the free list; no
//   clearing pass is needed, slot links read as their reset value until
//   written. while m_axis is stalled the result register holds, the input
//   register fills, and s_axis_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer_top #(
	parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
	parameter int SLOTS      = mqsb_pkg::SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // value[31:0]
	input  wire logic [3:0]  s_axis_tuser,  // kind[1:0], queue_number[3:2]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // front_value[31:0], back_value[63:32]
	output logic [2:0]       m_axis_tuser   // status[1:0], queue_empty[2]
);

	logic              valid_s1;
	mqsb_pkg::item_t   item_s1;
	logic              valid_s2;
	mqsb_pkg::result_t res_s2;
	mqsb_pkg::result_t res;
	logic              exec;

	assign exec          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (exec) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind         <= s_axis_tuser[1:0];
			item_s1.queue_number <= s_axis_tuser[3:2];
			item_s1.value        <= s_axis_tdata;
		end
		if (exec) begin
			res_s2 <= res;
		end
	end

	mqsb_core #(
		.NUM_QUEUES (NUM_QUEUES),
		.SLOTS      (SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.exec   (exec),
		.item   (item_s1),
		.result (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.back_value, res_s2.front_value};
	assign m_axis_tuser  = {res_s2.queue_empty, res_s2.status};

endmodule

`default_nettype wire

[dv/multi_queue_shared_buffer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top_tb
// stream-level test of the shared slot store with four fifo queues
// ----------------------------------------------------------------------------
// drives push, pop and peek operations on s_axis and predicts each result with
// its own linked-list copy of the slot store, free list and queue pointers.
// every m_axis result is checked field by field against the oldest prediction.
// random segments swing between push-heavy and pop-heavy mixes so that the
// store runs full and queues run dry; both sides idle in short bursts, and
// one long result stall backs the block up into its input.
// ----------------------------------------------------------------------------

module multi_queue_shared_buffer_top_tb;

	localparam int PTR_W = $clog2(mqsb_pkg::SLOTS_DEF + 1);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(mqsb_pkg::SLOTS_DEF);
	localparam logic [mqsb_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int          RANDOM_ITEMS   = 1630;
	localparam int          CALM_ITEMS     = 200;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          REPORT_LIMIT   = 10;

	class queue_scoreboard;
		logic signed [mqsb_pkg::DATA_W-1:0] slot_data [mqsb_pkg::SLOTS_DEF];
		logic [PTR_W-1:0]         slot_link [mqsb_pkg::SLOTS_DEF];
		logic [PTR_W-1:0]         queue_head [mqsb_pkg::NUM_QUEUES_DEF];
		logic [PTR_W-1:0]         queue_tail [mqsb_pkg::NUM_QUEUES_DEF];
		logic [PTR_W-1:0]         free_head;
		mqsb_pkg::result_t        pending_results [$];
		int                       failures;

		function new();
			failures = 0;
			for (int i = 0; i < mqsb_pkg::SLOTS_DEF; i++) begin
				slot_data[i] = '0;
				slot_link[i] = PTR_W'(i + 1);
			end
			for (int i = 0; i < mqsb_pkg::NUM_QUEUES_DEF; i++) begin
				queue_head[i] = NULL_PTR;
				queue_tail[i] = '0;
			end
			free_head = '0;
		endfunction

		// work out the result of one accepted operation and queue it
		function void note_operation(mqsb_pkg::item_t op);
			mqsb_pkg::result_t res;
			int                q;
			logic [PTR_W-1:0]  s;
			logic [PTR_W-1:0]  h;
			q               = op.queue_number;
			res.status      = mqsb_pkg::STAT_DONE;
			res.queue_empty = 1'b1;
			res.front_value = '0;
			res.back_value  = '0;
			if (q < mqsb_pkg::NUM_QUEUES_DEF) begin
				if (op.kind == mqsb_pkg::KIND_PUSH) begin
					s = free_head;
					if (s >= mqsb_pkg::SLOTS_DEF) begin
						res.status = mqsb_pkg::STAT_FULL;
					end else begin
						free_head = slot_link[s];
						if (queue_head[q] >= mqsb_pkg::SLOTS_DEF)
							queue_head[q] = s;
						else
							slot_link[queue_tail[q]] = s;
						slot_link[s]  = NULL_PTR;
						queue_tail[q] = s;
						slot_data[s]  = op.value;
					end
				end else if (op.kind == mqsb_pkg::KIND_POP) begin
					h = queue_head[q];
					if (h >= mqsb_pkg::SLOTS_DEF) begin
						res.status = mqsb_pkg::STAT_EMPTY;
					end else begin
						queue_head[q] = slot_link[h];
						slot_link[h]  = free_head;
						free_head     = h;
					end
				end
				if (queue_head[q] < mqsb_pkg::SLOTS_DEF) begin
					res.queue_empty = 1'b0;
					res.front_value = slot_data[queue_head[q]];
					res.back_value  = slot_data[queue_tail[q]];
				end
			end
			pending_results.push_back(res);
		endfunction

		function void flag(string what);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("[%0t] mismatch: %s", $time, what);
		endfunction

		function void check_result(mqsb_pkg::result_t got);
			mqsb_pkg::result_t want;
			if (pending_results.size() == 0) begin
				flag($sformatf("result with nothing expected: status %0d empty %0d front %h back %h",
					got.status, got.queue_empty, got.front_value, got.back_value));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.queue_empty !== want.queue_empty ||
						got.front_value !== want.front_value ||
						got.back_value !== want.back_value)
					flag($sformatf({"expected status %0d empty %0d front %h back %h, ",
						"got status %0d empty %0d front %h back %h"},
						want.status, want.queue_empty, want.front_value, want.back_value,
						got.status, got.queue_empty, got.front_value, got.back_value));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	queue_scoreboard board;
	int          ops_accepted;
	int          cycles;
	bit          calm;
	bit          hold_results;

	multi_queue_shared_buffer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_queue_shared_buffer_top test failed");
			$finish;
		end
	end

	// results first: nothing accepted at this edge can show up at the same edge
	always @(posedge clk) begin
		mqsb_pkg::result_t got;
		mqsb_pkg::item_t   op;
		if (arst_n && board != null) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status      = m_axis_tuser[1:0];
				got.queue_empty = m_axis_tuser[2];
				got.front_value = m_axis_tdata[31:0];
				got.back_value  = m_axis_tdata[63:32];
				board.check_result(got);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				op.kind         = s_axis_tuser[1:0];
				op.queue_number = s_axis_tuser[3:2];
				op.value        = s_axis_tdata;
				board.note_operation(op);
				ops_accepted++;
			end
		end
	end

	// result side: short random stalls, one long hold when asked
	initial begin : result_sink
		int idle_left;
		idle_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_results = 1'b0;
			end else if (idle_left > 0) begin
				m_axis_tready <= 1'b0;
				idle_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				idle_left = $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// entered and left at a falling edge; tvalid stays up on return
	task automatic send_operation(logic [mqsb_pkg::KIND_W-1:0] kind,
			logic [mqsb_pkg::QNUM_W-1:0] qn, logic [31:0] value);
		int target;
		target = ops_accepted + 1;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {qn, kind};
		s_axis_tdata  <= value;
		while (ops_accepted < target) @(negedge clk);
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending_results.size() > 0);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		int                          sent;
		int                          seg_len;
		int                          push_pct;
		int                          focus_q;
		int                          roll;
		logic [mqsb_pkg::KIND_W-1:0] kind;
		logic [mqsb_pkg::QNUM_W-1:0] qn;

		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		arst_n        = 1'b0;
		ops_accepted  = 0;
		cycles        = 0;
		calm          = 1'b0;
		hold_results  = 1'b0;
		board         = new();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queue, spare kind code, value extremes, drain past empty
		send_operation(mqsb_pkg::KIND_PEEK, 2'd0, 32'h1234_5678);
		send_operation(mqsb_pkg::KIND_POP,  2'd0, 32'h0);
		send_operation(KIND_SPARE,          2'd1, 32'hffff_ffff);
		send_operation(mqsb_pkg::KIND_PUSH, 2'd0, 32'h7fff_ffff);
		send_operation(mqsb_pkg::KIND_PUSH, 2'd0, 32'h8000_0000);
		send_operation(mqsb_pkg::KIND_PEEK, 2'd0, 32'h0);
		send_operation(mqsb_pkg::KIND_PUSH, 2'd1, 32'h0000_0000);
		send_operation(mqsb_pkg::KIND_PUSH, 2'd1, 32'hffff_ffff);
		send_operation(mqsb_pkg::KIND_PUSH, 2'd2, 32'h5555_5555);
		send_operation(mqsb_pkg::KIND_PUSH, 2'd3, 32'haaaa_aaaa);
		send_operation(KIND_SPARE,          2'd0, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd0, 32'hdead_beef);
		send_operation(mqsb_pkg::KIND_POP,  2'd0, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd0, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd1, 32'h0);
		send_operation(mqsb_pkg::KIND_PEEK, 2'd1, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd1, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd2, 32'h0);
		send_operation(mqsb_pkg::KIND_PEEK, 2'd3, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd3, 32'h0);
		send_operation(mqsb_pkg::KIND_POP,  2'd3, 32'h0);

		// segments alternate push-heavy and pop-heavy so the store fills and drains
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			seg_len  = $urandom_range(40, 120);
			push_pct = 10 + 20 * $urandom_range(0, 4);
			focus_q  = $urandom_range(0, 1) ?
				$urandom_range(0, mqsb_pkg::NUM_QUEUES_DEF - 1) : -1;
			for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
				if (sent == 400)
					hold_results = 1'b1;
				if (sent == 800)
					wait_for_drain();
				if (sent == RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
				roll = $urandom_range(0, 99);
				if (roll < push_pct)
					kind = mqsb_pkg::KIND_PUSH;
				else if (roll < push_pct + (100 - push_pct) * 8 / 10)
					kind = mqsb_pkg::KIND_POP;
				else if ($urandom_range(0, 3) == 0)
					kind = KIND_SPARE;
				else
					kind = mqsb_pkg::KIND_PEEK;
				if (focus_q >= 0 && $urandom_range(0, 3) != 0)
					qn = mqsb_pkg::QNUM_W'(focus_q);
				else
					qn = mqsb_pkg::QNUM_W'($urandom_range(0, mqsb_pkg::NUM_QUEUES_DEF - 1));
				send_operation(kind, qn, pick_value());
				sent++;
			end
		end

		wait_for_drain();
		repeat (10) @(posedge clk);
		if (board.failures == 0 && board.pending_results.size() == 0) begin
			$display("multi_queue_shared_buffer_top test passed");
		end else begin
			$display("multi_queue_shared_buffer_top test failed");
		end
		$finish;
	end

endmodule
